@@ sv/linear_rgb_to_oklab_macros.svh @@
// Assertion macros shared by the Oklab converter.
`ifndef LINEAR_RGB_TO_OKLAB_MACROS_SVH
`define LINEAR_RGB_TO_OKLAB_MACROS_SVH

// Condition and consequence in the same cycle.
`define OLAB_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define OLAB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/olab_pkg.sv @@
// Shared widths and fixed-point coefficients of the Oklab converter.
package olab_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CB = COMPONENT_BITS;

    // First matrix: unsigned Q0.30 coefficients.
    localparam int LMS_C_W   = 30;
    localparam int LMS_P_W   = LMS_C_W + CB;
    localparam int LMS_ACC_W = LMS_P_W + 2;

    // Cube root works on a 64-bit radicand and yields up to 22 bits.
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 22;
    localparam int CBRT_STEPS = 22;

    // Second matrix: signed Q.28 coefficients.
    localparam int LAB_C_W   = 31;
    localparam int LAB_P_W   = LAB_C_W + ROOT_W + 1;
    localparam int LAB_ACC_W = LAB_P_W + 2;
    localparam int SH_L      = 48 - CB;
    localparam int SH_AB     = 49 - CB;

    localparam int LMS_STAGES = 2;
    localparam int LAB_STAGES = 3;
    localparam int PIPE_DEPTH = LMS_STAGES + CBRT_STEPS + LAB_STAGES;

    // Round to nearest of n / 10^10 scaled by 2^sh, done at elaboration.
    function automatic longint dec10(longint unsigned n, int sh);
        longint unsigned scaled;
        scaled = n * (64'd1 << sh) + 64'd5000000000;
        return longint'(scaled / 64'd10000000000);
    endfunction

    localparam logic [LMS_C_W-1:0] LMS_C [3][3] = '{
        '{LMS_C_W'(dec10(64'd4122214708, 30)), LMS_C_W'(dec10(64'd5363325363, 30)),
          LMS_C_W'(dec10(64'd514459929, 30))},
        '{LMS_C_W'(dec10(64'd2119034982, 30)), LMS_C_W'(dec10(64'd6806995451, 30)),
          LMS_C_W'(dec10(64'd1073969566, 30))},
        '{LMS_C_W'(dec10(64'd883024619, 30)),  LMS_C_W'(dec10(64'd2817188376, 30)),
          LMS_C_W'(dec10(64'd6299787005, 30))}
    };

    localparam logic signed [LAB_C_W-1:0] LAB_C [3][3] = '{
        '{LAB_C_W'(dec10(64'd2104542553, 28)), LAB_C_W'(dec10(64'd7936177850, 28)),
          LAB_C_W'(-dec10(64'd40720468, 28))},
        '{LAB_C_W'(dec10(64'd19779984951, 28)), LAB_C_W'(-dec10(64'd24285922050, 28)),
          LAB_C_W'(dec10(64'd4505937099, 28))},
        '{LAB_C_W'(dec10(64'd259040371, 28)), LAB_C_W'(dec10(64'd7827717662, 28)),
          LAB_C_W'(-dec10(64'd8086757660, 28))}
    };

endpackage

@@ sv/olab_lms.sv @@
// First matrix stage: linear RGB to LMS, giving the cube-root radicands.
module olab_lms (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [olab_pkg::CB-1:0]                        i_red,
    input  logic [olab_pkg::CB-1:0]                        i_green,
    input  logic [olab_pkg::CB-1:0]                        i_blue,
    input  logic [olab_pkg::CB-1:0]                        i_alpha,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [2:0][olab_pkg::RAD_W-1:0]                o_rad,
    output logic [olab_pkg::CB-1:0]                        o_alpha
);

    logic [olab_pkg::LMS_STAGES-1:0] r_v;
    logic [olab_pkg::LMS_STAGES:0]   w_rdy;
    logic [2:0][2:0][olab_pkg::LMS_P_W-1:0] r_p;
    logic [2:0][olab_pkg::RAD_W-1:0]        r_rad;
    logic [2:0][olab_pkg::RAD_W-1:0]        n_rad;
    logic [olab_pkg::CB-1:0] r_a0;
    logic [olab_pkg::CB-1:0] r_a1;
    logic [2:0][olab_pkg::CB-1:0] w_rgb;

    assign w_rgb = {i_blue, i_green, i_red};

    always_comb begin
        w_rdy[olab_pkg::LMS_STAGES] = i_ready;
        for (int k = olab_pkg::LMS_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    // Sum the three products and round half up to Q0.30.
    always_comb begin
        logic [olab_pkg::LMS_ACC_W-1:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = olab_pkg::LMS_ACC_W'(r_p[i][0]) + olab_pkg::LMS_ACC_W'(r_p[i][1])
                + olab_pkg::LMS_ACC_W'(r_p[i][2])
                + (olab_pkg::LMS_ACC_W'(1) << (olab_pkg::CB - 1));
            n_rad[i] = olab_pkg::RAD_W'(acc >> olab_pkg::CB) << 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
        end
        if (w_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= olab_pkg::LMS_P_W'(olab_pkg::LMS_C[i][j])
                               * olab_pkg::LMS_P_W'(w_rgb[j]);
                end
            end
            r_a0 <= i_alpha;
        end
        if (w_rdy[1]) begin
            r_rad <= n_rad;
            r_a1  <= r_a0;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[olab_pkg::LMS_STAGES-1];
    assign o_rad   = r_rad;
    assign o_alpha = r_a1;

endmodule

@@ sv/olab_cbrt.sv @@
// Pipelined integer cube root, one result bit per stage for three channels.
module olab_cbrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0][olab_pkg::RAD_W-1:0]      i_rad,
    input  logic [olab_pkg::CB-1:0]              i_alpha,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0][olab_pkg::ROOT_W-1:0]     o_root,
    output logic [olab_pkg::CB-1:0]              o_alpha
);

    localparam int NS = olab_pkg::CBRT_STEPS;
    localparam int BW = 2 * olab_pkg::ROOT_W + 4;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    logic [2:0][olab_pkg::ROOT_W-1:0] r_r [NS];
    logic [2:0][olab_pkg::RAD_W-1:0]  r_n [NS];
    logic [olab_pkg::CB-1:0]          r_a [NS];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int SH = olab_pkg::RAD_W - 1 - 3 * k;

        logic [2:0][olab_pkg::ROOT_W-1:0] w_rin;
        logic [2:0][olab_pkg::RAD_W-1:0]  w_nin;
        logic [2:0][olab_pkg::ROOT_W-1:0] n_r;
        logic [2:0][olab_pkg::RAD_W-1:0]  n_n;
        logic                             w_vin;
        logic [olab_pkg::CB-1:0]          w_ain;

        if (k == 0) begin : g_first
            assign w_rin = '0;
            assign w_nin = i_rad;
            assign w_vin = i_valid;
            assign w_ain = i_alpha;
        end else begin : g_rest
            assign w_rin = r_r[k-1];
            assign w_nin = r_n[k-1];
            assign w_vin = r_v[k-1];
            assign w_ain = r_a[k-1];
        end

        // Try the next root bit: it fits when 3r(r+1)+1 fits in the remainder.
        always_comb begin
            logic [olab_pkg::ROOT_W-1:0] r2;
            logic [BW-1:0] b;
            for (int c = 0; c < 3; c++) begin
                r2 = {w_rin[c][olab_pkg::ROOT_W-2:0], 1'b0};
                b  = BW'(3) * (BW'(r2) * (BW'(r2) + BW'(1))) + BW'(1);
                if ((w_nin[c] >> SH) >= olab_pkg::RAD_W'(b)) begin
                    n_n[c] = w_nin[c] - (olab_pkg::RAD_W'(b) << SH);
                    n_r[c] = r2 | olab_pkg::ROOT_W'(1);
                end else begin
                    n_n[c] = w_nin[c];
                    n_r[c] = r2;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_vin;
            end
            if (w_rdy[k]) begin
                r_r[k] <= n_r;
                r_n[k] <= n_n;
                r_a[k] <= w_ain;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_root  = r_r[NS-1];
    assign o_alpha = r_a[NS-1];

endmodule

@@ sv/olab_lab.sv @@
// Second matrix stage: cube roots to Oklab L, a and b, rounded and saturated.
module olab_lab (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0][olab_pkg::ROOT_W-1:0]     i_root,
    input  logic [olab_pkg::CB-1:0]              i_alpha,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [olab_pkg::CB-1:0]              o_lightness,
    output logic signed [olab_pkg::CB-1:0]       o_green_red,
    output logic signed [olab_pkg::CB-1:0]       o_blue_yellow,
    output logic [olab_pkg::CB-1:0]              o_alpha
);

    localparam int AW = olab_pkg::LAB_ACC_W;
    localparam logic signed [AW-1:0] L_HI  = AW'((1 << olab_pkg::CB) - 1);
    localparam logic signed [AW-1:0] AB_HI = AW'((1 << (olab_pkg::CB - 1)) - 1);
    localparam logic signed [AW-1:0] AB_LO = -AW'(1 << (olab_pkg::CB - 1));

    logic [olab_pkg::LAB_STAGES-1:0] r_v;
    logic [olab_pkg::LAB_STAGES:0]   w_rdy;
    logic signed [olab_pkg::LAB_P_W-1:0] r_p [3][3];
    logic signed [AW-1:0] r_s [3];
    logic signed [AW-1:0] n_s [3];
    logic [olab_pkg::CB-1:0] r_a0;
    logic [olab_pkg::CB-1:0] r_a1;
    logic [olab_pkg::CB-1:0] r_a2;
    logic [olab_pkg::CB-1:0] r_l;
    logic signed [olab_pkg::CB-1:0] r_ga;
    logic signed [olab_pkg::CB-1:0] r_by;

    always_comb begin
        w_rdy[olab_pkg::LAB_STAGES] = i_ready;
        for (int k = olab_pkg::LAB_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    // Sum with a half-unit bias, then an arithmetic shift rounds half up.
    always_comb begin
        logic signed [AW-1:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = AW'(r_p[i][0]) + AW'(r_p[i][1]) + AW'(r_p[i][2]);
            if (i == 0) begin
                n_s[i] = (acc + (AW'(1) <<< (olab_pkg::SH_L - 1))) >>> olab_pkg::SH_L;
            end else begin
                n_s[i] = (acc + (AW'(1) <<< (olab_pkg::SH_AB - 1))) >>> olab_pkg::SH_AB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
        if (w_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= olab_pkg::LAB_P_W'(olab_pkg::LAB_C[i][j]
                                 * $signed({1'b0, i_root[j]}));
                end
            end
            r_a0 <= i_alpha;
        end
        if (w_rdy[1]) begin
            r_s  <= n_s;
            r_a1 <= r_a0;
        end
        if (w_rdy[2]) begin
            if (r_s[0] < 0) begin
                r_l <= '0;
            end else if (r_s[0] > L_HI) begin
                r_l <= L_HI[olab_pkg::CB-1:0];
            end else begin
                r_l <= r_s[0][olab_pkg::CB-1:0];
            end
            if (r_s[1] < AB_LO) begin
                r_ga <= AB_LO[olab_pkg::CB-1:0];
            end else if (r_s[1] > AB_HI) begin
                r_ga <= AB_HI[olab_pkg::CB-1:0];
            end else begin
                r_ga <= r_s[1][olab_pkg::CB-1:0];
            end
            if (r_s[2] < AB_LO) begin
                r_by <= AB_LO[olab_pkg::CB-1:0];
            end else if (r_s[2] > AB_HI) begin
                r_by <= AB_HI[olab_pkg::CB-1:0];
            end else begin
                r_by <= r_s[2][olab_pkg::CB-1:0];
            end
            r_a2 <= r_a1;
        end
    end

    assign o_ready       = w_rdy[0];
    assign o_valid       = r_v[olab_pkg::LAB_STAGES-1];
    assign o_lightness   = r_l;
    assign o_green_red   = r_ga;
    assign o_blue_yellow = r_by;
    assign o_alpha       = r_a2;

endmodule

@@ sv/linear_rgb_to_oklab.sv @@
// Top level of the linear RGB to Oklab pixel converter.
// This converter takes one linear RGB pixel with alpha per clock and returns
// its Oklab coordinates, with a sustained rate of one pixel per cycle while
// the output is not stalled. The LMS stages form the matrix products and
// their rounded sums, the cube-root stages resolve the root one bit per stage
// for all three cone responses at once, and the last stages form the second
// matrix, round and saturate. Every stage holds its own valid bit and moves
// on when the next stage is empty or moving, so bubbles close up under stall;
// if a stage is empty, a request is still accepted while a result waits.
`include "linear_rgb_to_oklab_macros.svh"

module linear_rgb_to_oklab (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [olab_pkg::CB-1:0]           i_red_in,
    input  logic [olab_pkg::CB-1:0]           i_green_in,
    input  logic [olab_pkg::CB-1:0]           i_blue_in,
    input  logic [olab_pkg::CB-1:0]           i_alpha_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [olab_pkg::CB-1:0]           o_lightness_out,
    output logic signed [olab_pkg::CB-1:0]    o_green_red_out,
    output logic signed [olab_pkg::CB-1:0]    o_blue_yellow_out,
    output logic [olab_pkg::CB-1:0]           o_alpha_out
);

    logic                                 w_lms_ready;
    logic                                 w_lms_valid;
    logic [2:0][olab_pkg::RAD_W-1:0]      w_rad;
    logic [olab_pkg::CB-1:0]              w_lms_alpha;
    logic                                 w_cbrt_ready;
    logic                                 w_cbrt_valid;
    logic [2:0][olab_pkg::ROOT_W-1:0]     w_root;
    logic [olab_pkg::CB-1:0]              w_cbrt_alpha;
    logic                                 w_lab_ready;

    // Requests in flight, kept for checking the pipeline never overfills.
    logic [5:0] r_count;

    olab_lms u_lms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_lms_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_alpha (i_alpha_in),
        .o_valid (w_lms_valid),
        .i_ready (w_cbrt_ready),
        .o_rad   (w_rad),
        .o_alpha (w_lms_alpha)
    );

    olab_cbrt u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lms_valid),
        .o_ready (w_cbrt_ready),
        .i_rad   (w_rad),
        .i_alpha (w_lms_alpha),
        .o_valid (w_cbrt_valid),
        .i_ready (w_lab_ready),
        .o_root  (w_root),
        .o_alpha (w_cbrt_alpha)
    );

    olab_lab u_lab (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_cbrt_valid),
        .o_ready       (w_lab_ready),
        .i_root        (w_root),
        .i_alpha       (w_cbrt_alpha),
        .o_valid       (o_valid),
        .i_ready       (!i_stall),
        .o_lightness   (o_lightness_out),
        .o_green_red   (o_green_red_out),
        .o_blue_yellow (o_blue_yellow_out),
        .o_alpha       (o_alpha_out)
    );

    assign o_stall = !w_lms_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 6'(i_valid && !o_stall) - 6'(o_valid && !i_stall);
        end
    end

    // The input can only be held off when every stage is full and the output is stalled.
    // A full pipeline pushes back in the same cycle as the output stall.
    // A stalled result stays valid and unchanged.
    `OLAB_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "bad stall")
    `OLAB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 6'(olab_pkg::PIPE_DEPTH), "overfill")
    `OLAB_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, r_count == 6'(olab_pkg::PIPE_DEPTH) && i_stall, o_stall, "no push back")
    `OLAB_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_lightness_out, o_green_red_out, o_blue_yellow_out, o_alpha_out}), "result moved")

endmodule
